// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, quiet while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/dcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_pkg
// Shared constants and types of the delimited command frame receiver.
// ----------------------------------------------------------------------------
package dcfr_pkg;

  localparam int FRAME_DEPTH_DEF = 32;

  localparam logic [7:0] HEAD_MARK = 8'h23;
  localparam logic [7:0] TAIL_MARK = 8'h21;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_REJECT    = 2'd1,
    ST_DELIVER   = 2'd2
  } take_status_t;

  typedef struct packed {
    take_status_t status;
    logic         has_byte;
    logic [7:0]   cmd_byte;
    logic         last;
  } res_t;

endpackage

// File: hdl/dcfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dcfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/dcfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_queue
// Two-entry command queue between the classifying front and the delivery back.
// ----------------------------------------------------------------------------
module dcfr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  input  logic             pop
);

  logic [1:0]       occ_r, occ_nxt;
  logic [WIDTH-1:0] ent0_r, ent1_r;

  assign can_push   = (occ_r != 2'd2);
  assign head_valid = (occ_r != 2'd0);
  assign head_data  = ent0_r;

  always_comb begin
    occ_nxt = occ_r;
    case ({push, pop})
      2'b10:   occ_nxt = occ_r + 2'd1;
      2'b01:   occ_nxt = occ_r - 2'd1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (occ_r == 2'd1) begin
          ent0_r <= push_data;
        end else begin
          ent0_r <= ent1_r;
          ent1_r <= push_data;
        end
      end
      2'b01: ent0_r <= ent1_r;
      2'b10: begin
        if (occ_r == 2'd0) begin
          ent0_r <= push_data;
        end else begin
          ent1_r <= push_data;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/dcfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_front
// Accepts bytes and take requests, tracks the frame and writes the store,
// and queues one command per take request for the delivery back end.
// ----------------------------------------------------------------------------
module dcfr_front #(
  parameter int FRAME_DEPTH = dcfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [7:0]                       in_byte,
  input  logic [7:0]                       in_room,
  input  logic                             release_i,
  output logic                             lock_o,
  input  logic                             q_ready,
  output logic                             q_push,
  output dcfr_pkg::take_status_t           q_status,
  output logic [$clog2(FRAME_DEPTH+1)-1:0] q_cnt,
  output logic                             we,
  output logic [$clog2(FRAME_DEPTH)-1:0]   waddr,
  output logic [7:0]                       wdata
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_RECV = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             tail_ok_r, tail_ok_nxt;
  logic             lock_r, lock_nxt;
  logic             acc;
  logic             has_room;
  logic [CMP_W-1:0] fill_m1;
  logic [CMP_W-1:0] room_m1;
  logic [CMP_W-1:0] n_take;

  assign in_ready = q_ready && !lock_r;
  assign lock_o   = lock_r;
  assign acc      = in_valid && in_ready;
  assign has_room = (fill_r < CNT_W'(FRAME_DEPTH));
  assign fill_m1  = CMP_W'(fill_r) - CMP_W'(1);
  assign room_m1  = CMP_W'(in_room) - CMP_W'(1);
  assign n_take   = (room_m1 < fill_m1) ? room_m1 : fill_m1;

  always_comb begin
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    tail_ok_nxt = tail_ok_r;
    lock_nxt    = lock_r;
    we          = 1'b0;
    waddr       = fill_r[ADDR_W-1:0];
    wdata       = in_byte;
    q_push      = 1'b0;
    q_status    = dcfr_pkg::ST_NOT_READY;
    q_cnt       = '0;

    if (release_i) begin
      lock_nxt = 1'b0;
    end

    if (acc && in_op == dcfr_pkg::OP_BYTE) begin
      unique case (phase_r)
        PH_RECV: begin
          if (in_byte == dcfr_pkg::TAIL_MARK) begin
            if (has_room) begin
              we          = 1'b1;
              fill_nxt    = fill_r + CNT_W'(1);
              tail_ok_nxt = 1'b1;
            end
            phase_nxt = PH_DONE;
          end else if (in_byte == dcfr_pkg::HEAD_MARK) begin
            we          = 1'b1;
            waddr       = '0;
            fill_nxt    = CNT_W'(1);
            tail_ok_nxt = 1'b0;
          end else if (has_room) begin
            we       = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
        default: begin
          if (in_byte == dcfr_pkg::HEAD_MARK) begin
            we          = 1'b1;
            waddr       = '0;
            fill_nxt    = CNT_W'(1);
            tail_ok_nxt = 1'b0;
            phase_nxt   = PH_RECV;
          end
        end
      endcase
    end

    if (acc && in_op == dcfr_pkg::OP_TAKE) begin
      q_push = 1'b1;
      if (in_room == 8'd0 || phase_r != PH_DONE) begin
        q_status = dcfr_pkg::ST_NOT_READY;
      end else if (!tail_ok_r) begin
        q_status  = dcfr_pkg::ST_REJECT;
        phase_nxt = PH_WAIT;
        fill_nxt  = '0;
      end else begin
        q_status  = dcfr_pkg::ST_DELIVER;
        q_cnt     = n_take[CNT_W-1:0];
        phase_nxt = PH_WAIT;
        fill_nxt  = '0;
        if (n_take != '0) begin
          lock_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      fill_r    <= '0;
      tail_ok_r <= 1'b0;
      lock_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      tail_ok_r <= tail_ok_nxt;
      lock_r    <= lock_nxt;
    end
  end

endmodule

// File: hdl/dcfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_back
// Executes queued take commands: emits status-only results directly or reads
// the held frame into a two-entry output buffer, one byte per cycle if free.
// ----------------------------------------------------------------------------
module dcfr_back #(
  parameter int FRAME_DEPTH = dcfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  dcfr_pkg::take_status_t           cmd_status,
  input  logic [$clog2(FRAME_DEPTH+1)-1:0] cmd_cnt,
  output logic                             cmd_pop,
  output logic                             re,
  output logic [$clog2(FRAME_DEPTH)-1:0]   raddr,
  input  logic [7:0]                       rdata,
  output logic                             release_o,
  output logic                             res_valid,
  input  logic                             res_ready,
  output dcfr_pkg::res_t                   res
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);

  logic                  busy_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [CNT_W-1:0]      rem_r;
  logic                  pend_r;
  logic                  pend_last_r;
  logic [1:0]            occ_r, occ_nxt;
  dcfr_pkg::res_t        ent0_r, ent1_r;
  logic                  pop;
  logic [2:0]            occ_after;
  logic                  can_issue;
  logic                  direct;
  logic                  load;
  logic                  push;
  dcfr_pkg::res_t        push_res;

  assign res_valid = (occ_r != 2'd0);
  assign res       = ent0_r;
  assign pop       = res_valid && res_ready;
  assign occ_after = 3'(occ_r) - 3'(pop);
  assign can_issue = (occ_after + 3'(pend_r)) < 3'd2;

  assign re        = busy_r && can_issue;
  assign raddr     = addr_r;
  assign release_o = re && (rem_r == CNT_W'(1));

  assign direct  = !busy_r && !pend_r && cmd_valid && (cmd_cnt == '0) && (occ_after < 3'd2);
  assign load    = !busy_r && cmd_valid && (cmd_cnt != '0);
  assign cmd_pop = direct || load;

  assign push = pend_r || direct;

  always_comb begin
    if (pend_r) begin
      push_res.status   = dcfr_pkg::ST_DELIVER;
      push_res.has_byte = 1'b1;
      push_res.cmd_byte = rdata;
      push_res.last     = pend_last_r;
    end else begin
      push_res.status   = cmd_status;
      push_res.has_byte = 1'b0;
      push_res.cmd_byte = 8'd0;
      push_res.last     = 1'b1;
    end
  end

  always_comb begin
    case ({push, pop})
      2'b10:   occ_nxt = occ_r + 2'd1;
      2'b01:   occ_nxt = occ_r - 2'd1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      occ_r       <= 2'd0;
    end else begin
      occ_r       <= occ_nxt;
      pend_r      <= re;
      pend_last_r <= release_o;
      if (load) begin
        busy_r <= 1'b1;
      end else if (release_o) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= '0;
      rem_r  <= cmd_cnt;
    end else if (re) begin
      addr_r <= addr_r + ADDR_W'(1);
      rem_r  <= rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (occ_r == 2'd1) begin
          ent0_r <= push_res;
        end else begin
          ent0_r <= ent1_r;
          ent1_r <= push_res;
        end
      end
      2'b01: ent0_r <= ent1_r;
      2'b10: begin
        if (occ_r == 2'd0) begin
          ent0_r <= push_res;
        end else begin
          ent1_r <= push_res;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/delimited_command_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver
// Captures one '#'...'!' command frame from serial bytes and hands it out on
// request as a stream of bytes with a last mark.
// ----------------------------------------------------------------------------
// A byte or a take request is accepted whenever the two-entry command queue
// has room; a byte gives no result, a take request gives one status result or
// a run of command bytes. A status result is registered in the command queue
// and then in the output buffer before it is ready. A run streams at one byte
// per cycle while the output buffer has room, set by the single read port of
// the frame store; its first byte passes the command queue, the command load,
// the store read and the output buffer. Input is held off from the take that
// starts a run until its last store read has been issued.
module delimited_command_frame_receiver #(
  parameter int FRAME_DEPTH = dcfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] rx_byte, [15:8] out_room
  input  logic [dcfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] cmd_byte
  output logic [dcfr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] take_status, [2] has_byte
  output logic [dcfr_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);

`include "assert_macros.svh"

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int CMD_W  = 2 + CNT_W;

  logic                   q_ready;
  logic                   q_push;
  dcfr_pkg::take_status_t q_status;
  logic [CNT_W-1:0]       q_cnt;
  logic                   head_valid;
  logic [CMD_W-1:0]       head_data;
  logic                   cmd_pop;
  dcfr_pkg::take_status_t cmd_status;
  logic [CNT_W-1:0]       cmd_cnt;
  logic                   store_lock;
  logic                   back_release;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [7:0]             ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [7:0]             ram_rdata;
  dcfr_pkg::res_t         res;

  assign cmd_status = dcfr_pkg::take_status_t'(head_data[CMD_W-1 -: 2]);
  assign cmd_cnt    = head_data[CNT_W-1:0];

  dcfr_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_room   (in_tdata[15:8]),
    .release_i (back_release),
    .lock_o    (store_lock),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_status  (q_status),
    .q_cnt     (q_cnt),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata)
  );

  dcfr_queue #(.WIDTH(CMD_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({q_status, q_cnt}),
    .can_push   (q_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (cmd_pop)
  );

  dcfr_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dcfr_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd_status (cmd_status),
    .cmd_cnt    (cmd_cnt),
    .cmd_pop    (cmd_pop),
    .re         (ram_re),
    .raddr      (ram_raddr),
    .rdata      (ram_rdata),
    .release_o  (back_release),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = res.cmd_byte;
  assign out_tuser = {res.has_byte, res.status};
  assign out_tlast = res.last;

  `ASSERT_IMPL(a_byte_is_delivery, clk, rst_n, out_tvalid && out_tuser[2],
    out_tuser[1:0] == dcfr_pkg::ST_DELIVER, "command byte without delivery status")
  `ASSERT_IMPL(a_status_only_is_last, clk, rst_n, out_tvalid && !out_tuser[2],
    out_tlast, "status-only result not marked last")
  `ASSERT_IMPL(a_release_under_lock, clk, rst_n, back_release, store_lock,
    "store released while not locked")
  `ASSERT_CLK(a_no_write_while_read, clk, rst_n, !(ram_we && ram_re),
    "frame store written while a delivery reads it")

endmodule

// File: test/delimited_command_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver_tb
// Drives serial bytes and take requests into the frame receiver and checks
// every delivered result against a cycle-free model of the frame capture.
// A short table covers reset, idle bytes, restarts, zero and full room and
// the empty delivery; random frames with random content, overlong frames,
// restarts and noise follow. Both stream sides idle at random, the result
// side holds off for a long stretch once, and the sender drains once.
// ----------------------------------------------------------------------------
module delimited_command_frame_receiver_tb;

  localparam int FRAME_DEPTH = dcfr_pkg::FRAME_DEPTH_DEF;
  localparam int DIR_ROWS    = 26;
  localparam int RAND_ITEMS  = 260;
  localparam int HOLD_CYCLES = 400;

  localparam dcfr_pkg::res_t RES_NOT_READY = '{dcfr_pkg::ST_NOT_READY, 1'b0, 8'h00, 1'b1};
  localparam dcfr_pkg::res_t RES_EMPTY_CMD = '{dcfr_pkg::ST_DELIVER, 1'b0, 8'h00, 1'b1};

  typedef enum logic [2:0] {
    RX_IDLE    = 3'b001,
    RX_COLLECT = 3'b010,
    RX_HELD    = 3'b100
  } rx_phase_t;

  typedef struct packed {
    logic           op;
    logic [7:0]     rx;
    logic [7:0]     room;
    logic           typed;
    dcfr_pkg::res_t want;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [dcfr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dcfr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [dcfr_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;

  rx_phase_t      rx_phase = RX_IDLE;
  int             held_len = 0;
  logic [7:0]     held_bytes [FRAME_DEPTH];
  dcfr_pkg::res_t take_results [$];
  dcfr_pkg::res_t cmd_expect_q [$];

  int  err_cnt = 0;
  int  items_sent = 0;
  bit  no_gaps = 1'b0;
  bit  hold_out = 1'b0;

  stim_row_t dir_tab [DIR_ROWS];

  delimited_command_frame_receiver #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic stim_row_t plain_row(logic op, logic [7:0] rx, logic [7:0] room);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.rx = rx;
    r.room = room;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic op, logic [7:0] rx, logic [7:0] room,
                                            dcfr_pkg::res_t want);
    stim_row_t r;
    r = plain_row(op, rx, room);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == dcfr_pkg::HEAD_MARK || b == dcfr_pkg::TAIL_MARK) b = b ^ 8'h80;
    return b;
  endfunction

  function automatic logic [7:0] pick_room();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 8'd0;
      1: return 8'd1;
      2, 3, 4: return 8'($urandom_range(2, 8));
      5: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Capture one byte or answer one take request into take_results.
  task automatic frame_capture_step(logic op, logic [7:0] rx, logic [7:0] room);
    int unsigned n;
    take_results.delete();
    if (op == dcfr_pkg::OP_BYTE) begin
      if (rx_phase == RX_COLLECT) begin
        if (rx == dcfr_pkg::TAIL_MARK) begin
          if (held_len < FRAME_DEPTH) begin
            held_bytes[held_len] = rx;
            held_len++;
          end
          rx_phase = RX_HELD;
        end else if (rx == dcfr_pkg::HEAD_MARK) begin
          held_bytes[0] = rx;
          held_len = 1;
        end else if (held_len < FRAME_DEPTH) begin
          held_bytes[held_len] = rx;
          held_len++;
        end else begin
          rx_phase = RX_IDLE;
        end
      end else if (rx == dcfr_pkg::HEAD_MARK) begin
        held_bytes[0] = rx;
        held_len = 1;
        rx_phase = RX_COLLECT;
      end
    end else if (room == 8'd0 || rx_phase != RX_HELD) begin
      take_results.push_back(RES_NOT_READY);
    end else if (held_len < 2 || held_bytes[held_len-1] != dcfr_pkg::TAIL_MARK) begin
      rx_phase = RX_IDLE;
      held_len = 0;
      take_results.push_back('{dcfr_pkg::ST_REJECT, 1'b0, 8'h00, 1'b1});
    end else begin
      n = held_len - 1;
      if (int'(room) - 1 < int'(n)) n = room - 1;
      rx_phase = RX_IDLE;
      held_len = 0;
      if (n == 0) begin
        take_results.push_back(RES_EMPTY_CMD);
      end else begin
        for (int i = 0; i < int'(n); i++)
          take_results.push_back('{dcfr_pkg::ST_DELIVER, 1'b1, held_bytes[i],
                                   (i + 1 == int'(n))});
      end
    end
  endtask

  task automatic send_item(stim_row_t row);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {row.room, row.rx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_capture_step(row.op, row.rx, row.room);
    if (row.typed) begin
      cmd_expect_q.push_back(row.want);
    end else begin
      foreach (take_results[i]) cmd_expect_q.push_back(take_results[i]);
    end
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(plain_row(dcfr_pkg::OP_BYTE, b, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_take(logic [7:0] room);
    send_item(plain_row(dcfr_pkg::OP_TAKE, 8'($urandom_range(0, 255)), room));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(int body_len);
    send_byte(dcfr_pkg::HEAD_MARK);
    repeat (body_len) send_byte(plain_byte());
    send_byte(dcfr_pkg::TAIL_MARK);
  endtask

  task automatic report_mismatch(string what, dcfr_pkg::res_t want, dcfr_pkg::res_t seen);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: status %0d/%0d has %0b/%0b byte %02h/%02h last %0b/%0b",
               $realtime, what, want.status, seen.status, want.has_byte, seen.has_byte,
               want.cmd_byte, seen.cmd_byte, want.last, seen.last);
  endtask

  always @(posedge clk) begin
    dcfr_pkg::res_t seen;
    dcfr_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tuser[1:0], out_tuser[2], out_tdata, out_tlast};
      if (cmd_expect_q.size() == 0) begin
        report_mismatch("unexpected result (exp/act)", '0, seen);
      end else begin
        want = cmd_expect_q.pop_front();
        if (seen !== want) report_mismatch("result mismatch (exp/act)", want, seen);
      end
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned kind;
    int          body_len;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    dir_tab[0]  = checked_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd5, RES_NOT_READY);
    dir_tab[1]  = plain_row(dcfr_pkg::OP_BYTE, 8'h00, 8'd0);
    dir_tab[2]  = plain_row(dcfr_pkg::OP_BYTE, 8'hFF, 8'd255);
    dir_tab[3]  = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::TAIL_MARK, 8'd0);
    dir_tab[4]  = checked_row(dcfr_pkg::OP_TAKE, 8'hFF, 8'd255, RES_NOT_READY);
    dir_tab[5]  = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::HEAD_MARK, 8'd0);
    dir_tab[6]  = plain_row(dcfr_pkg::OP_BYTE, 8'h00, 8'd0);
    dir_tab[7]  = plain_row(dcfr_pkg::OP_BYTE, 8'hFF, 8'd0);
    dir_tab[8]  = checked_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd9, RES_NOT_READY);
    dir_tab[9]  = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::HEAD_MARK, 8'd0);
    dir_tab[10] = plain_row(dcfr_pkg::OP_BYTE, 8'h41, 8'd0);
    dir_tab[11] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::TAIL_MARK, 8'd0);
    dir_tab[12] = plain_row(dcfr_pkg::OP_BYTE, 8'h5A, 8'd0);
    dir_tab[13] = checked_row(dcfr_pkg::OP_TAKE, 8'hFF, 8'd0, RES_NOT_READY);
    dir_tab[14] = plain_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd255);
    dir_tab[15] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::HEAD_MARK, 8'd0);
    dir_tab[16] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::TAIL_MARK, 8'd0);
    dir_tab[17] = checked_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd1, RES_EMPTY_CMD);
    dir_tab[18] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::HEAD_MARK, 8'd0);
    dir_tab[19] = plain_row(dcfr_pkg::OP_BYTE, 8'h5A, 8'd0);
    dir_tab[20] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::TAIL_MARK, 8'd0);
    dir_tab[21] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::HEAD_MARK, 8'd0);
    dir_tab[22] = plain_row(dcfr_pkg::OP_BYTE, 8'hC3, 8'd0);
    dir_tab[23] = plain_row(dcfr_pkg::OP_BYTE, dcfr_pkg::TAIL_MARK, 8'd0);
    dir_tab[24] = plain_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd2);
    dir_tab[25] = checked_row(dcfr_pkg::OP_TAKE, 8'h00, 8'd3, RES_NOT_READY);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // Fill the store to the brim: the closing mark finds no room.
    send_frame(FRAME_DEPTH - 1);
    send_take(8'd255);
    send_frame(FRAME_DEPTH - 2);
    send_take(8'd255);

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if (!hold_done && items_sent >= 100) begin
        hold_out  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 160) begin
        wait_drained();
        drain_done = 1'b1;
      end
      no_gaps = (items_sent >= 190 && items_sent < 250);
      body_len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(20, 33);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(body_len);
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
        send_take(pick_room());
      end else if (kind < 80) begin
        send_byte(dcfr_pkg::HEAD_MARK);
        repeat ($urandom_range(0, 4)) send_byte(plain_byte());
        send_frame(body_len);
        send_take(pick_room());
      end else if (kind < 88) begin
        send_byte(dcfr_pkg::HEAD_MARK);
        repeat (FRAME_DEPTH - 1) send_byte(plain_byte());
        send_byte(($urandom_range(0, 1) == 1) ? dcfr_pkg::TAIL_MARK : plain_byte());
        send_take(pick_room());
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(plain_row(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255))));
      end
    end
    no_gaps = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (cmd_expect_q.size() != 0) err_cnt++;

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
